// File: hdl/osd_pkg.sv
// shared constants and widths for the open syncmer detector
`timescale 1ns / 1ps

package osd_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int MAX_SMER_DEF   = 16;

    localparam int BASE_W      = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;

    localparam int SMER_LEN_W  = 5;
    localparam int KMER_LEN_W  = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SMER_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN = 1'd1;

    localparam logic [SMER_LEN_W-1:0] SMER_LEN_RST = 5'd8;
    localparam logic [KMER_LEN_W-1:0] KMER_LEN_RST = 7'd55;

endpackage

// File: hdl/open_syncmer_detector_core.sv
// the result of a base is registered and on m_tdata in the cycle after its transfer
// throughput: one base per cycle unless stalled, as the cell row shifts every transfer
// the output register stalls input only while a result waits and m_tready is low
// synchronous active-low reset clears config to defaults, s-mer, count and marks
// stored s-mers are not cleared; no clearing pass is needed
`timescale 1ns / 1ps

module open_syncmer_detector_core #(
    parameter int MAX_WINDOW = osd_pkg::MAX_WINDOW_DEF,
    parameter int MAX_SMER   = osd_pkg::MAX_SMER_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write port
    input  logic                             cfg_wr_en,
    input  logic [osd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [osd_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // base stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [osd_pkg::S_TDATA_W-1:0]    s_tdata,   // [1:0] base
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [osd_pkg::M_TDATA_W-1:0]    m_tdata    // [0] is_syncmer, [1] window_valid
);

    localparam int SMER_W = 2 * MAX_SMER;
    localparam int SL_W   = $clog2(MAX_SMER + 1);
    localparam int WL_W   = $clog2(MAX_WINDOW + 1);

    logic [osd_pkg::SMER_LEN_W-1:0] smer_len_reg;
    logic [osd_pkg::KMER_LEN_W-1:0] kmer_len_reg;
    logic [SMER_W-1:0]              cur_smer_reg, cur_smer_next;
    logic [WL_W-1:0]                bases_seen_reg, bases_seen_next;
    logic                           m_tvalid_reg;
    logic                           is_syncmer_reg, is_syncmer_next;
    logic                           window_valid_reg, window_valid_next;

    logic                  accept;
    logic [SL_W-1:0]       s_sat;
    logic [WL_W-1:0]       w_sat;
    logic [SMER_W-1:0]     smer_mask;
    logic [WL_W-1:0]       lead_off;
    logic [MAX_WINDOW:0]   mark_chain;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // config write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smer_len_reg <= osd_pkg::SMER_LEN_RST;
            kmer_len_reg <= osd_pkg::KMER_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                osd_pkg::REG_SMER_LEN: begin
                    smer_len_reg <= cfg_wr_data[osd_pkg::SMER_LEN_W-1:0];
                end
                osd_pkg::REG_KMER_LEN: begin
                    kmer_len_reg <= cfg_wr_data[osd_pkg::KMER_LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // lengths clipped to what the row can hold
    always_comb begin
        if (32'(smer_len_reg) > 32'(MAX_SMER)) begin
            s_sat = SL_W'(MAX_SMER);
        end else begin
            s_sat = SL_W'(smer_len_reg);
        end
        if (32'(kmer_len_reg) > 32'(MAX_WINDOW)) begin
            w_sat = WL_W'(MAX_WINDOW);
        end else begin
            w_sat = WL_W'(kmer_len_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < SMER_W; i++) begin
            smer_mask[i] = (32'(i >> 1) < 32'(s_sat));
        end
    end

    assign cur_smer_next = {cur_smer_reg[SMER_W-3:0], s_tdata[osd_pkg::BASE_W-1:0]}
                           & smer_mask;

    assign bases_seen_next = (32'(bases_seen_reg) < 32'(MAX_WINDOW))
                             ? bases_seen_reg + WL_W'(1) : bases_seen_reg;

    osd_cell_row #(
        .MAX_WINDOW (MAX_WINDOW),
        .SMER_W     (SMER_W)
    ) u_row (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_en   (accept),
        .cand       (cur_smer_next),
        .mark_chain (mark_chain)
    );

    // the window's first s-mer sits w - s entries back
    assign lead_off = WL_W'(32'(w_sat) - 32'(s_sat));

    always_comb begin
        window_valid_next = (bases_seen_next >= w_sat);
        is_syncmer_next   = 1'b0;
        if (window_valid_next) begin
            if (s_sat == '0) begin
                is_syncmer_next = 1'b1;
            end else if (32'(s_sat) <= 32'(w_sat)) begin
                is_syncmer_next = !mark_chain[lead_off];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_smer_reg   <= '0;
            bases_seen_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                cur_smer_reg   <= cur_smer_next;
                bases_seen_reg <= bases_seen_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            is_syncmer_reg   <= is_syncmer_next;
            window_valid_reg <= window_valid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(osd_pkg::M_TDATA_W-2){1'b0}}, window_valid_reg, is_syncmer_reg};

    // a flagged syncmer always has a full window behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (window_valid_reg || !is_syncmer_reg))
        else $error("syncmer flag without a full window");

    // base count saturates at the row length
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(bases_seen_reg) <= 32'(MAX_WINDOW))
        else $error("base count beyond row length");

    // every accepted base leaves a result behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid_reg)
        else $error("transfer without result");

    // input is only held off by a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready))
        else $error("input stalled with no pending result");

    // the count moves only on a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(bases_seen_reg))
        else $error("base count changed without transfer");

endmodule

// File: hdl/osd_cell.sv
// one window cell: stored s-mer with its beaten mark
`timescale 1ns / 1ps

module osd_cell #(
    parameter int SMER_W = 2 * osd_pkg::MAX_SMER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic [SMER_W-1:0] cand,
    input  logic [SMER_W-1:0] smer_in,
    input  logic              mark_in,
    output logic [SMER_W-1:0] smer_out,
    output logic              mark_out
);

    logic [SMER_W-1:0] smer_reg;
    logic              mark_reg;

    // mark as it stands once the new s-mer has been compared
    assign mark_out = mark_reg | (cand < smer_reg);
    assign smer_out = smer_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            smer_reg <= smer_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg <= 1'b0;
        end else if (shift_en) begin
            mark_reg <= mark_in;
        end
    end

endmodule

// File: hdl/osd_cell_row.sv
// row of window cells, newest s-mer enters cell 0
`timescale 1ns / 1ps

module osd_cell_row #(
    parameter int MAX_WINDOW = osd_pkg::MAX_WINDOW_DEF,
    parameter int SMER_W     = 2 * osd_pkg::MAX_SMER_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic [SMER_W-1:0]   cand,
    // bit k: updated mark of the entry k bases back, bit 0 is the new entry
    output logic [MAX_WINDOW:0] mark_chain
);

    logic [SMER_W-1:0] smer_link [0:MAX_WINDOW];
    logic [MAX_WINDOW:0] mark_link;

    assign smer_link[0] = cand;
    assign mark_link[0] = 1'b0;

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        osd_cell #(
            .SMER_W (SMER_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .cand     (cand),
            .smer_in  (smer_link[k]),
            .mark_in  (mark_link[k]),
            .smer_out (smer_link[k+1]),
            .mark_out (mark_link[k+1])
        );
    end

    assign mark_chain = mark_link;

endmodule

// File: test/open_syncmer_detector_core_tb.sv
// self-checking testbench for the open syncmer detector core
`timescale 1ns / 1ps

module open_syncmer_detector_core_tb;

    localparam int WIN_DEPTH = osd_pkg::MAX_WINDOW_DEF;

    // tracks the s-mer history and holds the flags each accepted base should produce
    class syncmer_tracker;
        logic [osd_pkg::SMER_LEN_W-1:0] smer_len_reg;
        logic [osd_pkg::KMER_LEN_W-1:0] kmer_len_reg;
        bit [31:0]   running_smer;
        bit [31:0]   smer_hist [WIN_DEPTH];
        bit          beaten [WIN_DEPTH];
        int unsigned bases_in;
        int unsigned newest;
        bit [1:0]    flag_q [$];   // {window_valid, is_syncmer}
        int          mismatches;
        int          checked;
        int          bases_total;

        function new();
            smer_len_reg = osd_pkg::SMER_LEN_RST;
            kmer_len_reg = osd_pkg::KMER_LEN_RST;
            running_smer = '0;
            foreach (smer_hist[j]) begin
                smer_hist[j] = '0;
                beaten[j]    = 1'b0;
            end
            bases_in    = 0;
            newest      = 0;
            mismatches  = 0;
            checked     = 0;
            bases_total = 0;
        endfunction

        function void write_reg(logic [osd_pkg::CFG_IDX_W-1:0] idx,
                                logic [osd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                osd_pkg::REG_SMER_LEN: smer_len_reg = data[osd_pkg::SMER_LEN_W-1:0];
                osd_pkg::REG_KMER_LEN: kmer_len_reg = data[osd_pkg::KMER_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_base(bit [1:0] b);
            int unsigned s;
            int unsigned w;
            int unsigned d;
            int unsigned slot;
            bit [63:0]   next;
            bit [63:0]   mask;
            bit          win_ok;
            bit          sync;
            s = 32'(smer_len_reg);
            w = 32'(kmer_len_reg);
            if (s > osd_pkg::MAX_SMER_DEF) s = osd_pkg::MAX_SMER_DEF;
            if (w > WIN_DEPTH) w = WIN_DEPTH;
            mask = (64'd1 << (2 * s)) - 64'd1;
            next = (({32'b0, running_smer} << 2) + 64'(b)) & mask;
            running_smer = next[31:0];
            // a strictly smaller newcomer beats every stored s-mer above it
            foreach (smer_hist[j])
                if (running_smer < smer_hist[j]) beaten[j] = 1'b1;
            newest = (newest + 1 >= WIN_DEPTH) ? 0 : newest + 1;
            smer_hist[newest] = running_smer;
            beaten[newest]    = 1'b0;
            if (bases_in < WIN_DEPTH) bases_in++;
            win_ok = bases_in >= w;
            sync   = 1'b0;
            if (win_ok) begin
                if (s == 0) begin
                    sync = 1'b1;
                end else if (s <= w) begin
                    // first s-mer of the window ended w-s bases back
                    d    = w - s;
                    slot = (newest >= d) ? newest - d : newest + WIN_DEPTH - d;
                    sync = !beaten[slot];
                end
            end
            flag_q.push_back({win_ok, sync});
            bases_total++;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
        endfunction

        function void check_flags(logic [osd_pkg::M_TDATA_W-1:0] tdata);
            bit [1:0] exp_flags;
            if (flag_q.size() == 0) begin
                report($sformatf("result with nothing expected: tdata=%h", tdata));
                return;
            end
            exp_flags = flag_q.pop_front();
            checked++;
            if (tdata[0] !== exp_flags[0])
                report($sformatf("is_syncmer: expected %0b, got %b", exp_flags[0], tdata[0]));
            if (tdata[1] !== exp_flags[1])
                report($sformatf("window_valid: expected %0b, got %b",
                                 exp_flags[1], tdata[1]));
        endfunction

        function int pending();
            return flag_q.size();
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [osd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [osd_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [osd_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [osd_pkg::M_TDATA_W-1:0]  m_tdata;

    syncmer_tracker tracker = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_start = 1'b0;
    int hold_cnt = 0;
    int settings_seen = 1;

    always #10 aclk = ~aclk;

    open_syncmer_detector_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // receiver side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_cnt   = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_flags(m_tdata);
    end

    initial begin
        #(4_000_000);
        $display("Some tests failed");
        $finish;
    end

    task automatic set_idle(input int mode);
        case (mode)
            1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
            3:       begin send_idle_pct = 22; recv_stall_pct = 22; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic write_cfg(input logic [osd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [osd_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        tracker.write_reg(idx, data);
        settings_seen++;
    endtask

    // offers one base and returns at the edge where it transfers
    task automatic send_base(input bit [1:0] b);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(osd_pkg::S_TDATA_W-osd_pkg::BASE_W){1'b0}}, b};
        do @(posedge aclk); while (!s_tready);
        tracker.add_base(b);
    endtask

    // stop offering and let every outstanding result through
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        // smer data, kmer data, bases, idle mode, low-entropy bias
        int ph_smer [12] = '{8, 1, 16, 127, 3, 0, 20, 4, 2, 5, 11, 6};
        int ph_kmer [12] = '{55, 2, 64, 127, 20, 5, 10, 4, 0, 12, 33, 64};
        int ph_len  [12] = '{150, 80, 150, 100, 120, 50, 50, 80, 30, 150, 100, 100};
        bit [1:0] mixed_run [13] = '{0, 0, 0, 3, 3, 3, 0, 1, 2, 3, 3, 0, 0};
        bit [1:0] fav;
        bit [1:0] b;
        int p;
        int i;
        bit biased;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset defaults, empty s-mer and window, ties and strict drops
        set_idle(0);
        for (i = 0; i < 3; i++) send_base(i[1:0]);
        drain();
        write_cfg(osd_pkg::REG_SMER_LEN, 7'd0);
        write_cfg(osd_pkg::REG_KMER_LEN, 7'd0);
        send_base(2'd3);
        send_base(2'd0);
        drain();
        write_cfg(osd_pkg::REG_SMER_LEN, 7'd1);
        send_base(2'd1);
        send_base(2'd2);
        drain();
        write_cfg(osd_pkg::REG_SMER_LEN, 7'd2);
        write_cfg(osd_pkg::REG_KMER_LEN, 7'd3);
        foreach (mixed_run[k]) send_base(mixed_run[k]);
        drain();
        // s-mer longer than the window
        write_cfg(osd_pkg::REG_SMER_LEN, 7'd5);
        write_cfg(osd_pkg::REG_KMER_LEN, 7'd2);
        send_base(2'd0);
        send_base(2'd3);
        drain();

        for (p = 0; p < 12; p++) begin
            write_cfg(osd_pkg::REG_SMER_LEN, ph_smer[p][osd_pkg::CFG_DATA_W-1:0]);
            write_cfg(osd_pkg::REG_KMER_LEN, ph_kmer[p][osd_pkg::CFG_DATA_W-1:0]);
            set_idle(p % 4);
            biased = (p % 3 == 1);
            fav = 2'($urandom_range(3));
            for (i = 0; i < ph_len[p]; i++) begin
                // hold the receiver off while bases keep coming, so the core backs up
                if (p == 4 && i == 30) hold_start = 1'b1;
                if (biased && $urandom_range(9) < 7) b = fav;
                else b = 2'($urandom_range(3));
                if ($urandom_range(49) == 0) fav = 2'($urandom_range(3));
                send_base(b);
            end
            drain();
        end

        set_idle(0);
        repeat (5) @(posedge aclk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));

        $display("Run covered %0d bases and %0d checked results over %0d register writes,",
                 tracker.bases_total, tracker.checked, settings_seen - 1);
        $display("with sender gaps, receiver stalls, a long hold-off and %0d mismatches.",
                 tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
